// ===== rtl/core/gga_pkg.sv =====
// Shared types, character codes and fixed-point helpers for the GGA position parser.
// No dependencies; every other file of the block refers to this package, by scoped names or by import.

package gga_pkg;

    // Fraction digits kept by the accumulators. Only seven of them can change the
    // result in units of 1e-7 degree, so the hardware keeps at most seven.
    localparam int FRACTION_DIGITS = 8;
    localparam int FRAC_KEEP       = (FRACTION_DIGITS < 7) ? FRACTION_DIGITS : 7;

    // Field widths.
    localparam int LAT_INT_W = 14;   // integer part of ddmm, saturates at 9999
    localparam int LON_INT_W = 17;   // integer part of dddmm, saturates at 99999
    localparam int FRAC_W    = 24;   // seven fraction digits, left aligned
    localparam int FC_W      = 3;    // count of fraction digits taken
    localparam int LAT_DEG_W = 7;
    localparam int LON_DEG_W = 10;
    localparam int MIN_W     = 7;    // whole minutes, 0 to 99
    localparam int X_W       = 30;   // minutes in units of 1e-7 minute
    localparam int Q_W       = 24;   // minutes converted to 1e-7 degree
    localparam int LAT_W     = 30;
    localparam int LON_W     = 34;

    localparam logic [LAT_INT_W-1:0] LAT_INT_MAX = 14'd9999;
    localparam logic [LON_INT_W-1:0] LON_INT_MAX = 17'd99999;
    localparam logic [X_W-1:0]       UNITS_PER_DEG = 30'd10000000;

    // Field positions within the sentence body.
    localparam logic [3:0] FIELD_LIMIT = 4'd15;
    localparam logic [3:0] LAT_FIELD   = 4'd2;
    localparam logic [3:0] LON_FIELD   = 4'd4;
    localparam logic [3:0] QUAL_FIELD  = 4'd6;
    localparam logic [3:0] MIN_FIELDS  = 4'd7;

    // Quality digit codes: digit plus one, or one of these.
    localparam logic [3:0] Q_EMPTY = 4'd0;
    localparam logic [3:0] Q_BAD   = 4'd15;

    // Character codes.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Reciprocals for the constant divisions.
    localparam logic [17:0] RECIP100 = 18'd167773;       // ceil(2^24 / 100)
    localparam logic [30:0] RECIP60  = 31'd1145324613;   // ceil(2^36 / 60)

    // How much of "$GP" has been seen.
    typedef enum logic [1:0] {
        PM_NONE,
        PM_DOLLAR,
        PM_DOLLAR_G
    } prefix_t;

    // Decision taken at the end of a line.
    typedef struct packed {
        logic       ok;
        logic [3:0] quality;
        logic       lat_upd;
        logic       lon_upd;
    } ctrl_t;

    // Word handed from the parser to the converter.
    typedef struct packed {
        logic                 end_of_line;
        ctrl_t                ctrl;
        logic [LAT_INT_W-1:0] lat_int;
        logic [FRAC_W-1:0]    lat_frac;
        logic [LON_INT_W-1:0] lon_int;
        logic [FRAC_W-1:0]    lon_frac;
    } line_t;

    // Integer division by 100 for values below 102400.
    function automatic logic [LON_DEG_W-1:0] div100(input logic [LON_INT_W-1:0] v);
        logic [34:0] p;
        p = 35'(v) * 35'(RECIP100);
        return p[33:24];
    endfunction

    // Integer division by 60 for values below 60 * 2^24.
    function automatic logic [Q_W-1:0] div60(input logic [X_W-1:0] v);
        logic [60:0] p;
        p = 61'(v) * 61'(RECIP60);
        return p[59:36];
    endfunction

endpackage

// ===== rtl/core/gga_parser.sv =====
// Byte-level sentence framing, field splitting and digit accumulation.
// Depends on gga_pkg; hands a line_t word to gga_convert at every line end.

module gga_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     byte_in,
    output gga_pkg::line_t line_o
);

    logic                          in_sentence_reg, in_sentence_next;
    gga_pkg::prefix_t              prefix_reg, prefix_next;
    logic [3:0]                    field_reg, field_next;
    logic                          saw_cr_reg, saw_cr_next;
    logic [3:0]                    quality_reg, quality_next;

    logic [gga_pkg::LAT_INT_W-1:0] lat_int_reg, lat_int_next;
    logic [gga_pkg::FRAC_W-1:0]    lat_frac_reg, lat_frac_next;
    logic [gga_pkg::FC_W-1:0]      lat_fc_reg, lat_fc_next;
    logic                          lat_pt_reg, lat_pt_next;
    logic                          lat_present_reg, lat_present_next;

    logic [gga_pkg::LON_INT_W-1:0] lon_int_reg, lon_int_next;
    logic [gga_pkg::FRAC_W-1:0]    lon_frac_reg, lon_frac_next;
    logic [gga_pkg::FC_W-1:0]      lon_fc_reg, lon_fc_next;
    logic                          lon_pt_reg, lon_pt_next;
    logic                          lon_present_reg, lon_present_next;

    logic                          line_end;
    logic                          is_digit;
    logic [3:0]                    digit;
    logic [19:0]                   lat_shift;
    logic [19:0]                   lon_shift;
    logic                          quality_ok;

    // Place value of the next fraction digit, counted from the first one.
    function automatic logic [gga_pkg::FRAC_W-1:0] frac_weight(
        input logic [gga_pkg::FC_W-1:0] fc
    );
        logic [gga_pkg::FRAC_W-1:0] w;
        case (fc)
            3'd0:    w = 24'd1000000;
            3'd1:    w = 24'd100000;
            3'd2:    w = 24'd10000;
            3'd3:    w = 24'd1000;
            3'd4:    w = 24'd100;
            3'd5:    w = 24'd10;
            3'd6:    w = 24'd1;
            default: w = 24'd0;
        endcase
        return w;
    endfunction

    assign is_digit  = (byte_in >= gga_pkg::CHAR_ZERO) && (byte_in <= gga_pkg::CHAR_NINE);
    assign digit     = byte_in[3:0];
    assign lat_shift = 20'(lat_int_reg) * 20'd10 + 20'(digit);
    assign lon_shift = 20'(lon_int_reg) * 20'd10 + 20'(digit);

    // Next state for one accepted word.
    always_comb begin
        in_sentence_next = in_sentence_reg;
        prefix_next      = prefix_reg;
        field_next       = field_reg;
        saw_cr_next      = saw_cr_reg;
        quality_next     = quality_reg;
        lat_int_next     = lat_int_reg;
        lat_frac_next    = lat_frac_reg;
        lat_fc_next      = lat_fc_reg;
        lat_pt_next      = lat_pt_reg;
        lat_present_next = lat_present_reg;
        lon_int_next     = lon_int_reg;
        lon_frac_next    = lon_frac_reg;
        lon_fc_next      = lon_fc_reg;
        lon_pt_next      = lon_pt_reg;
        lon_present_next = lon_present_reg;
        line_end         = 1'b0;

        if (accept) begin
            if (!in_sentence_reg) begin
                // Hunt for the "$GP" start of a sentence.
                unique case (prefix_reg)
                    gga_pkg::PM_DOLLAR_G: begin
                        if (byte_in == gga_pkg::CHAR_P) begin
                            in_sentence_next = 1'b1;
                            prefix_next      = gga_pkg::PM_NONE;
                            field_next       = 4'd0;
                            saw_cr_next      = 1'b0;
                            quality_next     = gga_pkg::Q_EMPTY;
                            lat_int_next     = '0;
                            lat_frac_next    = '0;
                            lat_fc_next      = '0;
                            lat_pt_next      = 1'b0;
                            lat_present_next = 1'b0;
                            lon_int_next     = '0;
                            lon_frac_next    = '0;
                            lon_fc_next      = '0;
                            lon_pt_next      = 1'b0;
                            lon_present_next = 1'b0;
                        end else if (byte_in == gga_pkg::CHAR_DOLLAR) begin
                            prefix_next = gga_pkg::PM_DOLLAR;
                        end else begin
                            prefix_next = gga_pkg::PM_NONE;
                        end
                    end
                    gga_pkg::PM_DOLLAR: begin
                        if (byte_in == gga_pkg::CHAR_G) begin
                            prefix_next = gga_pkg::PM_DOLLAR_G;
                        end else if (byte_in == gga_pkg::CHAR_DOLLAR) begin
                            prefix_next = gga_pkg::PM_DOLLAR;
                        end else begin
                            prefix_next = gga_pkg::PM_NONE;
                        end
                    end
                    default: begin
                        prefix_next = (byte_in == gga_pkg::CHAR_DOLLAR) ?
                                      gga_pkg::PM_DOLLAR : gga_pkg::PM_NONE;
                    end
                endcase
            end else if (byte_in == gga_pkg::CHAR_CR) begin
                saw_cr_next = 1'b1;
            end else if (byte_in == gga_pkg::CHAR_LF && saw_cr_reg) begin
                line_end         = 1'b1;
                in_sentence_next = 1'b0;
                prefix_next      = gga_pkg::PM_NONE;
                saw_cr_next      = 1'b0;
            end else begin
                saw_cr_next = 1'b0;
                if (byte_in == gga_pkg::CHAR_COMMA) begin
                    if (field_reg < gga_pkg::FIELD_LIMIT) begin
                        field_next = field_reg + 4'd1;
                    end
                end else if (field_reg == gga_pkg::LAT_FIELD) begin
                    // Latitude: saturating integer part, then up to seven fraction digits.
                    lat_present_next = 1'b1;
                    if (is_digit) begin
                        if (!lat_pt_reg) begin
                            lat_int_next = (lat_shift > 20'(gga_pkg::LAT_INT_MAX)) ?
                                           gga_pkg::LAT_INT_MAX :
                                           lat_shift[gga_pkg::LAT_INT_W-1:0];
                        end else if (lat_fc_reg < gga_pkg::FC_W'(gga_pkg::FRAC_KEEP)) begin
                            lat_frac_next = lat_frac_reg
                                + 24'(24'(digit) * frac_weight(lat_fc_reg));
                            lat_fc_next   = lat_fc_reg + 3'd1;
                        end
                    end else if (byte_in == gga_pkg::CHAR_POINT) begin
                        lat_pt_next = 1'b1;
                    end
                end else if (field_reg == gga_pkg::LON_FIELD) begin
                    // Longitude: same scheme with one more integer digit.
                    lon_present_next = 1'b1;
                    if (is_digit) begin
                        if (!lon_pt_reg) begin
                            lon_int_next = (lon_shift > 20'(gga_pkg::LON_INT_MAX)) ?
                                           gga_pkg::LON_INT_MAX :
                                           lon_shift[gga_pkg::LON_INT_W-1:0];
                        end else if (lon_fc_reg < gga_pkg::FC_W'(gga_pkg::FRAC_KEEP)) begin
                            lon_frac_next = lon_frac_reg
                                + 24'(24'(digit) * frac_weight(lon_fc_reg));
                            lon_fc_next   = lon_fc_reg + 3'd1;
                        end
                    end else if (byte_in == gga_pkg::CHAR_POINT) begin
                        lon_pt_next = 1'b1;
                    end
                end else if (field_reg == gga_pkg::QUAL_FIELD) begin
                    // Quality must be exactly one decimal digit.
                    if (quality_reg == gga_pkg::Q_EMPTY && is_digit) begin
                        quality_next = digit + 4'd1;
                    end else begin
                        quality_next = gga_pkg::Q_BAD;
                    end
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg <= 1'b0;
            prefix_reg      <= gga_pkg::PM_NONE;
            field_reg       <= 4'd0;
            saw_cr_reg      <= 1'b0;
            quality_reg     <= gga_pkg::Q_EMPTY;
            lat_pt_reg      <= 1'b0;
            lat_present_reg <= 1'b0;
            lon_pt_reg      <= 1'b0;
            lon_present_reg <= 1'b0;
            lat_fc_reg      <= '0;
            lon_fc_reg      <= '0;
        end else begin
            in_sentence_reg <= in_sentence_next;
            prefix_reg      <= prefix_next;
            field_reg       <= field_next;
            saw_cr_reg      <= saw_cr_next;
            quality_reg     <= quality_next;
            lat_pt_reg      <= lat_pt_next;
            lat_present_reg <= lat_present_next;
            lon_pt_reg      <= lon_pt_next;
            lon_present_reg <= lon_present_next;
            lat_fc_reg      <= lat_fc_next;
            lon_fc_reg      <= lon_fc_next;
        end
    end

    // Digit accumulators are cleared at every sentence start.
    always_ff @(posedge aclk) begin
        lat_int_reg  <= lat_int_next;
        lat_frac_reg <= lat_frac_next;
        lon_int_reg  <= lon_int_next;
        lon_frac_reg <= lon_frac_next;
    end

    // Accepted qualities are 1 to 6, 8 and 9, held as digit plus one.
    assign quality_ok = (quality_reg >= 4'd2) && (quality_reg <= 4'd10) && (quality_reg != 4'd8);

    always_comb begin
        line_o.end_of_line  = line_end;
        line_o.ctrl.ok      = (field_reg >= gga_pkg::MIN_FIELDS) && quality_ok;
        line_o.ctrl.quality = (quality_reg >= 4'd1 && quality_reg <= 4'd10) ?
                              (quality_reg - 4'd1) : 4'd0;
        line_o.ctrl.lat_upd = line_o.ctrl.ok && lat_present_reg;
        line_o.ctrl.lon_upd = line_o.ctrl.ok && lon_present_reg;
        line_o.lat_int      = lat_int_reg;
        line_o.lat_frac     = lat_frac_reg;
        line_o.lon_int      = lon_int_reg;
        line_o.lon_frac     = lon_frac_reg;
    end

endmodule

// ===== rtl/core/gga_convert.sv =====
// Four-stage conversion of the captured coordinates to 1e-7 degree, held position and
// result register. Depends on gga_pkg; fed by gga_parser through a line_t word.

module gga_convert (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gga_pkg::line_t               line_i,
    output logic                         in_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_fix_valid,
    output logic [3:0]                   m_fix_quality,
    output logic [gga_pkg::LAT_W-1:0]    m_latitude,
    output logic [gga_pkg::LON_W-1:0]    m_longitude
);

    // Stage 1: integer parts split into degrees.
    logic                          s1_valid_reg;
    gga_pkg::ctrl_t                s1_ctrl_reg;
    logic [gga_pkg::LAT_INT_W-1:0] s1_lat_int_reg;
    logic [gga_pkg::LON_INT_W-1:0] s1_lon_int_reg;
    logic [gga_pkg::FRAC_W-1:0]    s1_lat_frac_reg, s1_lon_frac_reg;
    logic [gga_pkg::LAT_DEG_W-1:0] s1_lat_deg_reg;
    logic [gga_pkg::LON_DEG_W-1:0] s1_lon_deg_reg;

    // Stage 2: whole minutes.
    logic                          s2_valid_reg;
    gga_pkg::ctrl_t                s2_ctrl_reg;
    logic [gga_pkg::FRAC_W-1:0]    s2_lat_frac_reg, s2_lon_frac_reg;
    logic [gga_pkg::LAT_DEG_W-1:0] s2_lat_deg_reg;
    logic [gga_pkg::LON_DEG_W-1:0] s2_lon_deg_reg;
    logic [gga_pkg::MIN_W-1:0]     s2_lat_min_reg, s2_lon_min_reg;

    // Stage 3: scaled minutes and degrees.
    logic                          s3_valid_reg;
    gga_pkg::ctrl_t                s3_ctrl_reg;
    logic [gga_pkg::X_W-1:0]       s3_lat_x_reg, s3_lon_x_reg;
    logic [gga_pkg::LAT_W-1:0]     s3_lat_degu_reg;
    logic [gga_pkg::LON_W-1:0]     s3_lon_degu_reg;

    // Stage 4: minutes divided by 60; waits here while the result register is full.
    logic                          s4_valid_reg, s4_valid_next;
    gga_pkg::ctrl_t                s4_ctrl_reg;
    logic [gga_pkg::Q_W-1:0]       s4_lat_q_reg, s4_lon_q_reg;
    logic [gga_pkg::LAT_W-1:0]     s4_lat_degu_reg;
    logic [gga_pkg::LON_W-1:0]     s4_lon_degu_reg;

    // Held position and result register.
    logic [gga_pkg::LAT_W-1:0]     held_lat_reg, held_lat_next;
    logic [gga_pkg::LON_W-1:0]     held_lon_reg, held_lon_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_fix_valid_reg;
    logic [3:0]                    m_fix_quality_reg;
    logic [gga_pkg::LAT_W-1:0]     m_latitude_reg;
    logic [gga_pkg::LON_W-1:0]     m_longitude_reg;

    logic                          out_take;
    logic                          pipe_busy;
    logic                          out_stalled;

    assign out_take    = s4_valid_reg && (!m_valid_reg || m_ready);
    assign pipe_busy   = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;
    assign out_stalled = m_valid_reg && !m_ready;

    // A line end may enter unless a result is in flight behind a full result register.
    assign in_ready = !(pipe_busy && out_stalled);

    assign s4_valid_next = s3_valid_reg || (s4_valid_reg && !out_take);
    assign m_valid_next  = out_take || (m_valid_reg && !m_ready);

    // New held position at the moment a result leaves stage 4.
    always_comb begin
        held_lat_next = held_lat_reg;
        held_lon_next = held_lon_reg;
        if (out_take && s4_ctrl_reg.lat_upd) begin
            held_lat_next = s4_lat_degu_reg + gga_pkg::LAT_W'(s4_lat_q_reg);
        end
        if (out_take && s4_ctrl_reg.lon_upd) begin
            held_lon_next = s4_lon_degu_reg + gga_pkg::LON_W'(s4_lon_q_reg);
        end
    end

    // Valid bits and held position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            held_lat_reg <= '0;
            held_lon_reg <= '0;
        end else begin
            s1_valid_reg <= line_i.end_of_line;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s4_valid_next;
            m_valid_reg  <= m_valid_next;
            held_lat_reg <= held_lat_next;
            held_lon_reg <= held_lon_next;
        end
    end

    // Stage 1: degrees by reciprocal multiplication.
    always_ff @(posedge aclk) begin
        if (line_i.end_of_line) begin
            s1_ctrl_reg     <= line_i.ctrl;
            s1_lat_int_reg  <= line_i.lat_int;
            s1_lon_int_reg  <= line_i.lon_int;
            s1_lat_frac_reg <= line_i.lat_frac;
            s1_lon_frac_reg <= line_i.lon_frac;
            s1_lat_deg_reg  <= gga_pkg::LAT_DEG_W'(
                gga_pkg::div100(gga_pkg::LON_INT_W'(line_i.lat_int)));
            s1_lon_deg_reg  <= gga_pkg::div100(line_i.lon_int);
        end
    end

    // Stage 2: whole minutes left after the degrees.
    always_ff @(posedge aclk) begin
        s2_ctrl_reg     <= s1_ctrl_reg;
        s2_lat_frac_reg <= s1_lat_frac_reg;
        s2_lon_frac_reg <= s1_lon_frac_reg;
        s2_lat_deg_reg  <= s1_lat_deg_reg;
        s2_lon_deg_reg  <= s1_lon_deg_reg;
        s2_lat_min_reg  <= gga_pkg::MIN_W'(s1_lat_int_reg
            - gga_pkg::LAT_INT_W'(gga_pkg::LAT_INT_W'(s1_lat_deg_reg) * 14'd100));
        s2_lon_min_reg  <= gga_pkg::MIN_W'(s1_lon_int_reg
            - gga_pkg::LON_INT_W'(gga_pkg::LON_INT_W'(s1_lon_deg_reg) * 17'd100));
    end

    // Stage 3: minutes in 1e-7 minute, degrees in 1e-7 degree.
    always_ff @(posedge aclk) begin
        s3_ctrl_reg     <= s2_ctrl_reg;
        s3_lat_x_reg    <= gga_pkg::X_W'(s2_lat_min_reg) * gga_pkg::UNITS_PER_DEG
                           + gga_pkg::X_W'(s2_lat_frac_reg);
        s3_lon_x_reg    <= gga_pkg::X_W'(s2_lon_min_reg) * gga_pkg::UNITS_PER_DEG
                           + gga_pkg::X_W'(s2_lon_frac_reg);
        s3_lat_degu_reg <= gga_pkg::LAT_W'(s2_lat_deg_reg)
                           * gga_pkg::LAT_W'(gga_pkg::UNITS_PER_DEG);
        s3_lon_degu_reg <= gga_pkg::LON_W'(s2_lon_deg_reg)
                           * gga_pkg::LON_W'(gga_pkg::UNITS_PER_DEG);
    end

    // Stage 4: minutes over 60, loaded only when stage 3 holds a line.
    always_ff @(posedge aclk) begin
        if (s3_valid_reg) begin
            s4_ctrl_reg     <= s3_ctrl_reg;
            s4_lat_q_reg    <= gga_pkg::div60(s3_lat_x_reg);
            s4_lon_q_reg    <= gga_pkg::div60(s3_lon_x_reg);
            s4_lat_degu_reg <= s3_lat_degu_reg;
            s4_lon_degu_reg <= s3_lon_degu_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (out_take) begin
            m_fix_valid_reg   <= s4_ctrl_reg.ok;
            m_fix_quality_reg <= s4_ctrl_reg.quality;
            m_latitude_reg    <= held_lat_next;
            m_longitude_reg   <= held_lon_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_fix_valid   = m_fix_valid_reg;
    assign m_fix_quality = m_fix_quality_reg;
    assign m_latitude    = m_latitude_reg;
    assign m_longitude   = m_longitude_reg;

endmodule

// ===== rtl/core/nmea_gga_position_parser.sv =====
// Top level of the GGA position parser: byte parser and coordinate converter.
// Depends on gga_pkg, gga_parser and gga_convert.
//
// Usage:
//   Input channel s_valid / s_ready / s_byte_in carries the receiver stream, one
//   character per word. Sentences open with "$GP" and close with CR LF; fields are
//   split at commas. Field 2 is ddmm.mmmm latitude, field 4 dddmm.mmmm longitude and
//   field 6 the fix quality.
//   Output channel m_valid / m_ready carries one word per sentence-ending LF:
//   m_fix_valid, m_fix_quality and the held m_latitude / m_longitude in 1e-7 degree.
//   Throughput is one character per cycle while s_ready is high. After its LF is
//   accepted, a result passes the four conversion stages (divide by 100, minutes,
//   scaling, divide by 60) and the result register.
//   If the receiver stalls, the result waits in the result register while further
//   characters are still taken; only when a second result is in the conversion stages
//   behind it does s_ready drop until the receiver takes the first one.
//   Reset (aresetn low at a clock edge) drops out of any sentence, empties the
//   conversion stages and the result register, and clears the held position to zero.

module nmea_gga_position_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_byte_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_fix_valid,
    output logic [3:0]                m_fix_quality,
    output logic [gga_pkg::LAT_W-1:0] m_latitude,
    output logic [gga_pkg::LON_W-1:0] m_longitude
);

    gga_pkg::line_t line;
    logic           accept;

    assign accept = s_valid && s_ready;

    gga_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .byte_in (s_byte_in),
        .line_o  (line)
    );

    gga_convert u_convert (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .line_i        (line),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fix_valid   (m_fix_valid),
        .m_fix_quality (m_fix_quality),
        .m_latitude    (m_latitude),
        .m_longitude   (m_longitude)
    );

endmodule

// ===== rtl/core/gga_checker.sv =====
// Port-level checks for the GGA position parser, bound to its top level.
// Depends on gga_pkg for the coordinate widths.

module gga_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_fix_valid,
    input logic [3:0]                m_fix_quality,
    input logic [gga_pkg::LAT_W-1:0] m_latitude,
    input logic [gga_pkg::LON_W-1:0] m_longitude
);

    // A stalled result word stays offered.
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its position.
    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_latitude) && $stable(m_longitude))
        else $error("result position changed while stalled");

    // The quality digit is a decimal digit.
    a_quality_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fix_quality <= 4'd9)
        else $error("quality digit out of range");

    // A fix is only reported for an accepted quality.
    a_fix_quality: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fix_valid |-> m_fix_quality != 4'd0 && m_fix_quality != 4'd7)
        else $error("fix reported for a rejected quality");

    // Converted latitude never exceeds 99 degrees plus 99.9999999 minutes.
    a_lat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_latitude <= 30'd1006666666)
        else $error("latitude beyond the convertible range");

endmodule

bind nmea_gga_position_parser gga_checker u_gga_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_fix_valid   (m_fix_valid),
    .m_fix_quality (m_fix_quality),
    .m_latitude    (m_latitude),
    .m_longitude   (m_longitude)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the GGA position parser, driven one character per word.
// Depends on gga_pkg and on the nmea_gga_position_parser top level; it needs nothing else.
// A local predictor follows every accepted character and queues the position report due.

module tb;
    import gga_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BYTES  = 950;
    localparam int RANDOM_FIXES  = 40;

    // Quality codes are the digit plus one.
    localparam logic [3:0] Q_DIGIT_1 = 4'd2;
    localparam logic [3:0] Q_DIGIT_7 = 4'd8;
    localparam logic [3:0] Q_DIGIT_9 = 4'd10;

    typedef struct packed {
        logic             fix_ok;
        logic [3:0]       quality;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
    } fix_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [7:0]       s_byte_in = 8'h00;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic             m_fix_valid;
    logic [3:0]       m_fix_quality;
    logic [LAT_W-1:0] m_latitude;
    logic [LON_W-1:0] m_longitude;

    nmea_gga_position_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fix_valid   (m_fix_valid),
        .m_fix_quality (m_fix_quality),
        .m_latitude    (m_latitude),
        .m_longitude   (m_longitude)
    );

    fix_t fixes_due[$];
    int   error_count    = 0;
    int   bytes_sent     = 0;
    int   fixes_queued   = 0;
    int   fixes_checked  = 0;
    int   fixes_accepted = 0;
    int   cycle_count    = 0;
    bit   tx_steady      = 1'b0;
    bit   rx_steady      = 1'b0;
    int   hold_requests  = 0;
    int   holds_served   = 0;
    int   rx_hold_left   = 0;
    int   rx_stall_left  = 0;

    // Predictor state of the sentence framer and field accumulators.
    logic        in_line;
    prefix_t     prefix_seen;
    logic [3:0]  field_idx;
    logic        cr_pending;
    logic [63:0] lat_acc, lon_acc;
    int          lat_frac_n, lon_frac_n;
    logic        lat_point, lon_point;
    logic        lat_seen, lon_seen;
    logic [3:0]  quality_code;
    logic [63:0] lat_hold, lon_hold;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a run that does not drain in time is a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d reports still due", cycle_count,
                 fixes_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] ten_pow(int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) p = p * 64'd10;
        return p;
    endfunction

    // Fixed-point ddmm.mmmm value to units of 1e-7 degree.
    function automatic logic [63:0] coord_units(logic [63:0] acc, int frac_n,
                                                logic [63:0] deg_mod);
        logic [63:0] one, scaled, deg, min_s;
        one    = ten_pow(FRACTION_DIGITS);
        scaled = acc * ten_pow((frac_n <= FRACTION_DIGITS) ? FRACTION_DIGITS - frac_n : 0);
        deg    = ((scaled / one) / 64'd100) % deg_mod;
        min_s  = scaled - deg * 64'd100 * one;
        return deg * 64'd10000000 + (min_s * 64'd10000000) / (64'd60 * one);
    endfunction

    function automatic void clear_line_fields();
        field_idx    = '0;
        cr_pending   = 1'b0;
        lat_acc      = '0;
        lon_acc      = '0;
        lat_frac_n   = 0;
        lon_frac_n   = 0;
        lat_point    = 1'b0;
        lon_point    = 1'b0;
        lat_seen     = 1'b0;
        lon_seen     = 1'b0;
        quality_code = Q_EMPTY;
    endfunction

    // One character of a coordinate field: digits, the first point, or skipped.
    task automatic take_coord_char(input logic [7:0] c, input logic [63:0] int_max,
                                   inout logic [63:0] acc, inout int frac_n,
                                   inout logic point, inout logic seen);
        logic [63:0] v;
        seen = 1'b1;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (!point) begin
                v   = acc * 64'd10 + 64'(c - CHAR_ZERO);
                acc = (v > int_max) ? int_max : v;
            end else if (frac_n < FRACTION_DIGITS) begin
                acc = acc * 64'd10 + 64'(c - CHAR_ZERO);
                frac_n++;
            end
        end else if (c == CHAR_POINT && !point) begin
            point = 1'b1;
        end
    endtask

    // Follows one accepted character and queues a report at a line-ending LF.
    task automatic predict_char(input logic [7:0] c);
        fix_t f;
        logic ok;
        if (!in_line) begin
            if (prefix_seen == PM_DOLLAR_G && c == CHAR_P) begin
                in_line     = 1'b1;
                prefix_seen = PM_NONE;
                clear_line_fields();
            end else if (prefix_seen == PM_DOLLAR && c == CHAR_G) begin
                prefix_seen = PM_DOLLAR_G;
            end else begin
                prefix_seen = (c == CHAR_DOLLAR) ? PM_DOLLAR : PM_NONE;
            end
        end else if (c == CHAR_CR) begin
            cr_pending = 1'b1;
        end else if (c == CHAR_LF && cr_pending) begin
            ok = (field_idx >= MIN_FIELDS) && quality_code >= Q_DIGIT_1 &&
                 quality_code <= Q_DIGIT_9 && quality_code != Q_DIGIT_7;
            if (ok && lat_seen)
                lat_hold = coord_units(lat_acc, lat_frac_n, 64'd100) & 64'h3FFF_FFFF;
            if (ok && lon_seen)
                lon_hold = coord_units(lon_acc, lon_frac_n, 64'd1000) & 64'h3_FFFF_FFFF;
            f.fix_ok  = ok;
            f.quality = (quality_code > Q_EMPTY && quality_code <= Q_DIGIT_9) ?
                        quality_code - 4'd1 : 4'd0;
            f.lat     = lat_hold[LAT_W-1:0];
            f.lon     = lon_hold[LON_W-1:0];
            fixes_due.push_back(f);
            fixes_queued++;
            in_line     = 1'b0;
            prefix_seen = PM_NONE;
            cr_pending  = 1'b0;
        end else begin
            cr_pending = 1'b0;
            if (c == CHAR_COMMA) begin
                if (field_idx < FIELD_LIMIT) field_idx++;
            end else if (field_idx == LAT_FIELD) begin
                take_coord_char(c, 64'(LAT_INT_MAX), lat_acc, lat_frac_n, lat_point, lat_seen);
            end else if (field_idx == LON_FIELD) begin
                take_coord_char(c, 64'(LON_INT_MAX), lon_acc, lon_frac_n, lon_point, lon_seen);
            end else if (field_idx == QUAL_FIELD) begin
                if (quality_code == Q_EMPTY && c >= CHAR_ZERO && c <= CHAR_NINE)
                    quality_code = 4'(c - CHAR_ZERO) + 4'd1;
                else
                    quality_code = Q_BAD;
            end
        end
    endtask

    // Offers one character word and waits for it to be taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_char(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line(input string body);
        send_text(body);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    function automatic string digit_run(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic string one_char(int c);
        string t;
        t    = "?";
        t[0] = c[7:0];
        return t;
    endfunction

    function automatic string pick(string a, string b);
        return $urandom_range(0, 1) ? a : b;
    endfunction

    // Coordinate text: mostly well formed, sometimes empty, odd or too long.
    function automatic string rand_coord(int int_len);
        string s;
        int    k;
        k = $urandom_range(0, 19);
        if (k == 0) return "";
        s = digit_run((k < 15) ? int_len : $urandom_range(0, 8));
        if (k != 16) s = {s, ".", digit_run($urandom_range(0, 11))};
        if (k == 17) s = {s, ".", digit_run(2)};
        if (k == 18) s = {s, one_char($urandom_range(65, 90)), digit_run(2)};
        return s;
    endfunction

    function automatic string rand_quality();
        int k;
        k = $urandom_range(0, 19);
        if (k < 16) return $sformatf("%0d", $urandom_range(0, 9));
        if (k == 16) return "";
        if (k == 17) return digit_run(2);
        if (k == 18) return one_char($urandom_range(65, 90));
        return {digit_run(1), one_char($urandom_range(97, 122))};
    endfunction

    function automatic string rand_body();
        string s;
        int    extra;
        s = {"$GP", pick("GGA", digit_run($urandom_range(0, 3)))};
        s = {s, ",", digit_run($urandom_range(0, 6))};
        s = {s, ",", rand_coord(4), ",", pick("N", "S")};
        s = {s, ",", rand_coord(5), ",", pick("E", "W")};
        s = {s, ",", rand_quality()};
        extra = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        repeat (extra) s = {s, ",", digit_run($urandom_range(0, 3))};
        return s;
    endfunction

    // Result side: random stalls, plus the long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            rx_hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 2) == 0) rx_stall_left = pick_gap();
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Compare every accepted report word with the oldest one due.
    always @(posedge aclk) begin : check_reports
        fix_t want;
        if (aresetn && m_valid && m_ready) begin
            if (fixes_due.size() == 0) begin
                error_count++;
                $display("%0t: report with none due, expected nothing, actual %0d/%0d/%0d/%0d",
                         $time, m_fix_valid, m_fix_quality, m_latitude, m_longitude);
            end else begin
                want = fixes_due.pop_front();
                check_field("fix_valid", 64'(want.fix_ok), 64'(m_fix_valid));
                check_field("fix_quality", 64'(want.quality), 64'(m_fix_quality));
                check_field("latitude", 64'(want.lat), 64'(m_latitude));
                check_field("longitude", 64'(want.lon), 64'(m_longitude));
                fixes_checked++;
                if (want.fix_ok) fixes_accepted++;
            end
        end
    end

    task automatic test_plain_fix();
        send_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    endtask

    // Every quality digit, 0 and 7 among them.
    task automatic test_each_quality();
        for (int q = 0; q <= 9; q++)
            send_line($sformatf("$GPGGA,,%04d.%04d,N,%05d.%05d,E,%0d,07",
                                $urandom_range(0, 9999), $urandom_range(0, 9999),
                                $urandom_range(0, 99999), $urandom_range(0, 99999), q));
    endtask

    // Largest and smallest values, integer saturation and dropped fraction digits.
    task automatic test_value_extremes();
        send_line("$GPGGA,,9999.99999999,N,99999.99999999,E,9,1");
        send_line("$GPGGA,,0000.0000,N,00000.0000,E,1,1");
        send_line("$GPGGA,,1234567.123456789012,S,12345678.99999999999,W,8,1");
        send_line("$GPGGA,,.,N,.,E,6,1");
    endtask

    task automatic test_stray_chars();
        send_line("$GPGGA,,48A07.0.38,N,0+11.3:1,E,2,x");
    endtask

    // Empty coordinates keep the held position.
    task automatic test_empty_coords();
        send_line("$GPGGA,,,,,,4,05");
        send_line("$GPGGA,,,,01500.25,,5,05");
    endtask

    task automatic test_bad_quality();
        send_line("$GPGGA,,3000.5,,04000.5,,12,1");
        send_line("$GPGGA,,3100.5,,04100.5,,a,1");
        send_line("$GPGGA,,3200.5,,04200.5,,,1");
    endtask

    // Six fields are too few; seven are enough.
    task automatic test_field_count();
        send_line("$GPGGA,,1.5,,2.5,,1");
        send_line("$GPGGA,,1.5,,2.5,,1,");
        send_line("$GP,,0130.5,,00245.75,,3,,,,,,,,,,,,,,,,,,,,");
    endtask

    // Lone CR, LF without CR, and doubled CR before the closing LF.
    task automatic test_line_endings();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_text("$GPGGA,,49");
        send_byte(CHAR_CR);
        send_text("12");
        send_byte(CHAR_LF);
        send_text(".5,,00713.25,,6,");
        send_byte(CHAR_CR);
        send_line("");
    endtask

    // Prefix search restarts and a dollar inside a sentence.
    task automatic test_framing();
        send_text("x$G$GPGGA,$GP,4000.0,,02000.0,,3,1");
        send_line("");
        send_line("$$GP,,1111.1,,22222.2,,5,,");
    endtask

    task automatic test_byte_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$GPGGA,,1");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_line("2.5,,3.5,,2,9");
    endtask

    // The result side holds off while short sentences keep coming.
    task automatic test_back_pressure();
        hold_requests++;
        tx_steady = 1'b1;
        repeat (8) send_line($sformatf("$GP,,%04d.5,,%05d.5,,1,", $urandom_range(0, 9999),
                                       $urandom_range(0, 99999)));
        tx_steady = 1'b0;
    endtask

    // Mostly well-formed random sentences, some cut short or malformed, some noise.
    task automatic test_random_traffic();
        int    start_bytes, start_fixes, mode, cut;
        string body;
        start_bytes = bytes_sent;
        start_fixes = fixes_queued;
        while (bytes_sent - start_bytes < RANDOM_BYTES ||
               fixes_queued - start_fixes < RANDOM_FIXES) begin
            if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
            if ($urandom_range(0, 9) == 0) rx_steady = !rx_steady;
            mode = $urandom_range(0, 99);
            if (mode < 80) begin
                send_line(rand_body());
            end else if (mode < 90) begin
                body = rand_body();
                cut  = $urandom_range(1, body.len());
                send_text(body.substr(0, cut - 1));
                if ($urandom_range(0, 1)) send_byte(CHAR_CR);
                else send_byte(CHAR_LF);
            end else begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        in_line     = 1'b0;
        prefix_seen = PM_NONE;
        clear_line_fields();
        lat_hold    = '0;
        lon_hold    = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_fix();
        test_each_quality();
        test_value_extremes();
        test_stray_chars();
        test_empty_coords();
        test_bad_quality();
        test_field_count();
        test_line_endings();
        test_framing();
        test_byte_extremes();
        test_back_pressure();
        test_random_traffic();

        s_valid <= 1'b0;
        while (fixes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters in %0d cycles; %0d position reports compared,",
                 bytes_sent, cycle_count, fixes_checked);
        $display("%0d with an accepted fix, %0d mismatches.", fixes_accepted, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== nmea_gga_position_parser.f =====
rtl/core/gga_pkg.sv
rtl/core/gga_parser.sv
rtl/core/gga_convert.sv
rtl/core/nmea_gga_position_parser.sv
rtl/core/gga_checker.sv
sim/tb.sv
